// File: rtl/core/hpps_pkg.sv
// Shared types and constants for the health-priority path selector.
package hpps_pkg;

    // Default table depth
    localparam int TABLE_DEPTH_DEF = 8;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 3;
    localparam int HEALTH_W = 2;
    localparam int LIMIT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    // Largest request limit
    localparam int LIMIT_MAX = (1 << LIMIT_W) - 1;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_SET    = 2'd1,
        CMD_SINGLE = 2'd2,
        CMD_MULTI  = 2'd3
    } t_cmd;

    // Health codes
    localparam logic [HEALTH_W-1:0] H_UNKNOWN  = 2'd0;
    localparam logic [HEALTH_W-1:0] H_HEALTHY  = 2'd1;
    localparam logic [HEALTH_W-1:0] H_DEGRADED = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE   = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/core/health_priority_path_select.sv
// Top level: path table with health codes, single and multipath selection.
//
//  channel   | direction | handshake               | fields
//  ----------+-----------+-------------------------+------------------------------------------
//  request   | in        | start & !busy           | i_cmd i_entry_index i_health i_path_limit
//  result    | out       | o_valid, one cycle each | o_path_index o_status o_last_of_run
//            |           |                         | o_active_count
//
// Append, set health and select single: one result the cycle after the request,
// busy stays low. Multipath select on a non-empty table with a nonzero limit: the single read
// port of the health memory is swept twice, then one result per cycle for each chosen
// entry; busy stays high until the last result is on the ports. Reset (synchronous)
// empties the table and sets one active path. Results cannot be stalled by the receiver.
module health_priority_path_select
    #(
        parameter int TABLE_DEPTH = hpps_pkg::TABLE_DEPTH_DEF
    )
    (
        input  logic                          i_clk,
        input  logic                          i_rst_n,
        input  logic                          start,
        output logic                          busy,
        input  logic [hpps_pkg::CMD_W-1:0]    i_cmd,
        input  logic [hpps_pkg::IDX_W-1:0]    i_entry_index,
        input  logic [hpps_pkg::HEALTH_W-1:0] i_health,
        input  logic [hpps_pkg::LIMIT_W-1:0]  i_path_limit,
        output logic                          o_valid,
        output logic [hpps_pkg::IDX_W-1:0]    o_path_index,
        output logic [hpps_pkg::STATUS_W-1:0] o_status,
        output logic                          o_last_of_run,
        output logic [hpps_pkg::COUNT_W-1:0]  o_active_count
    );
    import hpps_pkg::*;

    // Table address, table count and active-list geometry
    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW   = (CNTW > IDX_W) ? CNTW : IDX_W;
    localparam int LIST_D = (TABLE_DEPTH < LIMIT_MAX) ? TABLE_DEPTH : LIMIT_MAX;
    localparam int LLW    = (LIST_D > 1) ? $clog2(LIST_D) : 1;

    t_state                r_state, n_state;
    logic [CNTW-1:0]       r_entry_count, n_entry_count;
    logic [COUNT_W-1:0]    r_active_total, n_active_total;
    logic                  r_pass, n_pass;
    logic [CNTW-1:0]       r_scan_idx, n_scan_idx;
    logic [COUNT_W-1:0]    r_chosen, n_chosen;
    logic [COUNT_W-1:0]    r_emit, n_emit;
    logic [LIMIT_W-1:0]    r_limit, n_limit;

    logic                  r_valid, n_valid;
    logic [IDX_W-1:0]      r_path_index, n_path_index;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_last, n_last;
    logic [COUNT_W-1:0]    r_active_count, n_active_count;

    logic [HEALTH_W-1:0]   r_health_mem [TABLE_DEPTH];
    logic [HEALTH_W-1:0]   r_rd_health;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_act [LIST_D];

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [HEALTH_W-1:0]   mem_wdata;
    logic                  rd_en;
    logic                  list_we;
    logic                  take;
    logic                  emit_last;

    // Candidate test for the entry just read
    always_comb begin
        if (!r_pass) begin
            take = (r_rd_health == H_UNKNOWN) || (r_rd_health == H_HEALTHY);
        end else begin
            take = (r_rd_health == H_DEGRADED);
        end
    end

    assign emit_last = ((r_emit + COUNT_W'(1)) == r_chosen);

    // Sequencer: next state, table updates, result staging
    always_comb begin
        n_state        = r_state;
        n_entry_count  = r_entry_count;
        n_active_total = r_active_total;
        n_pass         = r_pass;
        n_scan_idx     = r_scan_idx;
        n_chosen       = r_chosen;
        n_emit         = r_emit;
        n_limit        = r_limit;
        n_valid        = 1'b0;
        n_path_index   = r_path_index;
        n_status       = r_status;
        n_last         = r_last;
        n_active_count = r_active_count;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = i_health;
        rd_en          = 1'b0;
        list_we        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_valid        = 1'b1;
                    n_path_index   = '0;
                    n_status       = STAT_DONE;
                    n_last         = 1'b1;
                    n_active_count = r_active_total;
                    unique case (t_cmd'(i_cmd))
                        CMD_APPEND: begin
                            if (int'(r_entry_count) >= TABLE_DEPTH) begin
                                n_status = STAT_REJECT;
                            end else begin
                                mem_we        = 1'b1;
                                mem_waddr     = AW'(r_entry_count);
                                n_path_index  = IDX_W'(r_entry_count);
                                n_entry_count = r_entry_count + CNTW'(1);
                            end
                        end
                        CMD_SET: begin
                            if (CMPW'(i_entry_index) >= CMPW'(r_entry_count)) begin
                                n_status = STAT_REJECT;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(i_entry_index);
                            end
                        end
                        CMD_SINGLE: begin
                            if (CMPW'(i_entry_index) >= CMPW'(r_entry_count)) begin
                                n_status = STAT_REJECT;
                            end else begin
                                n_path_index   = i_entry_index;
                                n_active_total = COUNT_W'(1);
                                n_active_count = COUNT_W'(1);
                            end
                        end
                        CMD_MULTI: begin
                            if (r_entry_count == '0 || i_path_limit == '0) begin
                                n_status = STAT_NONE;
                            end else begin
                                n_valid    = 1'b0;
                                n_state    = ST_SCAN;
                                n_pass     = 1'b0;
                                n_scan_idx = '0;
                                n_chosen   = '0;
                                n_limit    = i_path_limit;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Evaluate the entry read last cycle
                if (r_rd_vld && take && (r_chosen < r_limit)
                        && (int'(r_chosen) < TABLE_DEPTH)) begin
                    list_we  = 1'b1;
                    n_chosen = r_chosen + COUNT_W'(1);
                end
                // Issue the next read, or close the pass once drained
                if (r_scan_idx < r_entry_count) begin
                    rd_en      = 1'b1;
                    n_scan_idx = r_scan_idx + CNTW'(1);
                end else if (!r_rd_vld) begin
                    if (!r_pass) begin
                        n_pass     = 1'b1;
                        n_scan_idx = '0;
                    end else if (r_chosen == '0) begin
                        n_valid        = 1'b1;
                        n_path_index   = '0;
                        n_status       = STAT_NONE;
                        n_last         = 1'b1;
                        n_active_count = '0;
                        n_active_total = '0;
                        n_state        = ST_IDLE;
                    end else begin
                        n_active_total = r_chosen;
                        n_emit         = '0;
                        n_state        = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                n_valid        = 1'b1;
                n_path_index   = r_act[LLW'(r_emit)];
                n_status       = STAT_DONE;
                n_last         = emit_last;
                n_active_count = r_chosen;
                n_emit         = r_emit + COUNT_W'(1);
                if (emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count  <= '0;
            r_active_total <= COUNT_W'(1);
            r_valid        <= 1'b0;
            r_rd_vld       <= 1'b0;
        end else begin
            r_entry_count  <= n_entry_count;
            r_active_total <= n_active_total;
            r_valid        <= n_valid;
            r_rd_vld       <= rd_en;
        end
    end

    // Working and result payload registers
    always_ff @(posedge i_clk) begin
        r_pass         <= n_pass;
        r_scan_idx     <= n_scan_idx;
        r_chosen       <= n_chosen;
        r_emit         <= n_emit;
        r_limit        <= n_limit;
        r_path_index   <= n_path_index;
        r_status       <= n_status;
        r_last         <= n_last;
        r_active_count <= n_active_count;
    end

    // Health memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_health_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_health <= r_health_mem[AW'(r_scan_idx)];
            r_rd_idx    <= IDX_W'(r_scan_idx);
        end
    end

    // Active list, filled in choice order
    always_ff @(posedge i_clk) begin
        if (list_we) begin
            r_act[LLW'(r_chosen)] <= r_rd_idx;
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_path_index   = r_path_index;
    assign o_status       = r_status;
    assign o_last_of_run  = r_last;
    assign o_active_count = r_active_count;

    // A run of results is contiguous up to its last marker
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |=> r_valid)
        else $error("result run broken before last marker");

    // An accepted request either answers next cycle or starts a scan
    a_req_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_valid || r_state == ST_SCAN)
        else $error("request neither answered nor scanning");

    // Nothing-chosen results are single and carry index zero
    a_none_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == STAT_NONE |-> r_last && r_path_index == '0)
        else $error("bad nothing-chosen result");

    // The scan never picks more than requested
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_chosen <= r_limit)
        else $error("chosen count exceeds limit");

    // The table never grows past its depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_entry_count) <= TABLE_DEPTH)
        else $error("entry count beyond table depth");

endmodule
